@@ rtl/core/crte_pkg.sv @@
// Package for the content router table engine: payload structs, status codes,
// table constants and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none
package crte_pkg;

  localparam int RouteDepth = 16;
  localparam int PendingDepth = 16;
  localparam int MaxInterfaces = 8;
  localparam int RouteIdxW = $clog2(RouteDepth);
  localparam int PendIdxW = $clog2(PendingDepth);
  localparam int IfCntW = 4;

  localparam logic [1:0] PKT_REQUEST = 2'd0;
  localparam logic [1:0] PKT_RESPONSE = 2'd1;
  localparam logic [1:0] PKT_ANNOUNCE = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NO_ROUTE = 3'd1;
  localparam logic [2:0] ST_NO_PENDING = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  localparam logic [1:0] REG_NUM_INTERFACES = 2'd0;
  localparam logic [3:0] NumInterfacesReset = 4'd4;

  typedef struct packed {
    logic [1:0] packet_type;
    logic [7:0] content_id;
    logic [7:0] host_or_hops;
    logic [2:0] in_interface;
  } in_item_t;

  typedef struct packed {
    logic       send;
    logic [2:0] out_interface;
    logic [7:0] hops_out;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic load;        // capture the accepted beat, clear search results
    logic scan;        // evaluate entry at scan index
    logic commit;      // apply table update from search results
    logic emit_bcast;  // broadcast beat for current interface index
    logic emit_single; // single result beat
    logic if_step;     // advance interface index
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] packet_type;
    logic       scan_done;
    logic       if_done;   // interface index reached the broadcast limit
    logic       if_skip;   // current interface is the arrival interface
    logic       if_last;   // no later interface will be sent
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/content_router_table_engine_top.sv @@
// Top level of the content router table engine: APB register, controller
// and datapath. Depends on crte_pkg, crte_ctrl, crte_datapath.
//
// Usage: packet headers enter on in_item/in_valid/in_ready, one beat each.
// Result beats leave on out_item/out_valid/out_ready; last marks the final
// beat of a header. Requests, responses and unknown types give one beat,
// announcements one beat per other interface below num_interfaces (at most
// 8), or one non-send beat if there is no such interface. Each header is
// loaded, both 16-entry tables are scanned together, one entry per cycle,
// the update is committed, broadcasts step through the interface indices,
// and a closing state waits until the last beat is taken. A stalled receiver
// holds the current beat and halts the controller; the next header is
// accepted only after the last beat was taken. Reset empties both tables
// and sets num_interfaces to 4. num_interfaces is at APB address 0 and must
// be written only while the block is idle, which the block does not enforce.
`default_nettype none
module content_router_table_engine_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  crte_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output crte_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  crte_pkg::dp_cmd_t  cmd;
  crte_pkg::dp_stat_t stat;
  logic [3:0] num_interfaces;

  assign pready = 1'b1;

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      num_interfaces <= crte_pkg::NumInterfacesReset;
    end else if (psel && penable && pwrite && paddr == crte_pkg::REG_NUM_INTERFACES) begin
      num_interfaces <= pwdata[3:0];
    end
  end

  assign prdata = (paddr == crte_pkg::REG_NUM_INTERFACES) ? {28'd0, num_interfaces} : 32'd0;

  crte_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
  );

  crte_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .in_item(in_item),
    .num_interfaces(num_interfaces), .res(out_item)
  );
endmodule
`default_nettype wire

@@ rtl/core/crte_datapath.sv @@
// Datapath: route and pending tables in flops with valid bits, one-entry-per-
// cycle scan, broadcast interface counter and output beat formation.
// Depends on crte_pkg.
`default_nettype none
module crte_datapath (
  input  logic                clk,
  input  logic                rst,
  input  crte_pkg::dp_cmd_t   cmd,
  output crte_pkg::dp_stat_t  stat,
  input  crte_pkg::in_item_t  in_item,
  input  logic [3:0]          num_interfaces,
  output crte_pkg::out_item_t res
);
  localparam int ScanW = (crte_pkg::RouteIdxW > crte_pkg::PendIdxW) ?
                         crte_pkg::RouteIdxW : crte_pkg::PendIdxW;
  localparam int ScanMax = (crte_pkg::RouteDepth > crte_pkg::PendingDepth) ?
                           crte_pkg::RouteDepth : crte_pkg::PendingDepth;

  logic [crte_pkg::RouteDepth-1:0]   r_valid;
  logic [7:0] r_content [crte_pkg::RouteDepth];
  logic [7:0] r_hops    [crte_pkg::RouteDepth];
  logic [2:0] r_iface   [crte_pkg::RouteDepth];
  logic [crte_pkg::PendingDepth-1:0] p_valid;
  logic [7:0] p_content [crte_pkg::PendingDepth];
  logic [7:0] p_host    [crte_pkg::PendingDepth];
  logic [2:0] p_iface   [crte_pkg::PendingDepth];

  crte_pkg::in_item_t item;
  logic [ScanW:0] scan_idx;
  logic r_hit, r_free_f, p_hit, p_free_f;
  logic [crte_pkg::RouteIdxW-1:0] r_hit_idx, r_free_idx;
  logic [crte_pkg::PendIdxW-1:0]  p_hit_idx, p_free_idx;
  logic [3:0] if_idx;
  logic [3:0] limit;
  logic [2:0] status;

  // Clamp broadcast count to the interface limit
  always_comb begin
    if (num_interfaces > 4'(crte_pkg::MaxInterfaces)) begin
      limit = 4'(crte_pkg::MaxInterfaces);
    end else begin
      limit = num_interfaces;
    end
  end

  assign stat.packet_type = item.packet_type;
  assign stat.scan_done = (scan_idx == (ScanW+1)'(ScanMax));
  assign stat.if_done = (if_idx >= limit);
  assign stat.if_skip = (if_idx[2:0] == item.in_interface) && (if_idx[3] == 1'b0);
  assign stat.if_last = ((if_idx + 4'd1) >= limit) ||
                        (((if_idx + 4'd1) == {1'b0, item.in_interface}) &&
                         ((if_idx + 4'd2) >= limit));

  // Status of the item from the search results
  always_comb begin
    status = crte_pkg::ST_OK;
    case (item.packet_type)
      crte_pkg::PKT_REQUEST: begin
        if (!p_hit && !p_free_f) begin
          status = crte_pkg::ST_FULL;
        end else if (!r_hit) begin
          status = crte_pkg::ST_NO_ROUTE;
        end
      end
      crte_pkg::PKT_RESPONSE: begin
        if (!p_hit) status = crte_pkg::ST_NO_PENDING;
      end
      crte_pkg::PKT_ANNOUNCE: begin
        if (!r_hit && !r_free_f) status = crte_pkg::ST_FULL;
      end
      default: status = crte_pkg::ST_UNKNOWN;
    endcase
  end

  // Scan, track interface index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
      scan_idx <= '0;
      if_idx <= '0;
      r_hit <= 1'b0;
      r_free_f <= 1'b0;
      p_hit <= 1'b0;
      p_free_f <= 1'b0;
      r_hit_idx <= '0;
      r_free_idx <= '0;
      p_hit_idx <= '0;
      p_free_idx <= '0;
    end else begin
      if (cmd.scan) begin
        scan_idx <= scan_idx + 1'b1;
        if (scan_idx < (ScanW+1)'(crte_pkg::RouteDepth)) begin
          if (r_valid[scan_idx[crte_pkg::RouteIdxW-1:0]]) begin
            if (!r_hit && r_content[scan_idx[crte_pkg::RouteIdxW-1:0]] == item.content_id) begin
              r_hit <= 1'b1;
              r_hit_idx <= scan_idx[crte_pkg::RouteIdxW-1:0];
            end
          end else if (!r_free_f) begin
            r_free_f <= 1'b1;
            r_free_idx <= scan_idx[crte_pkg::RouteIdxW-1:0];
          end
        end
        if (scan_idx < (ScanW+1)'(crte_pkg::PendingDepth)) begin
          if (p_valid[scan_idx[crte_pkg::PendIdxW-1:0]]) begin
            if (!p_hit && p_content[scan_idx[crte_pkg::PendIdxW-1:0]] == item.content_id &&
                p_host[scan_idx[crte_pkg::PendIdxW-1:0]] == item.host_or_hops) begin
              p_hit <= 1'b1;
              p_hit_idx <= scan_idx[crte_pkg::PendIdxW-1:0];
            end
          end else if (!p_free_f) begin
            p_free_f <= 1'b1;
            p_free_idx <= scan_idx[crte_pkg::PendIdxW-1:0];
          end
        end
      end
      if (cmd.if_step) if_idx <= if_idx + 4'd1;
    end
  end

  // Apply the table update
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= '0;
      p_valid <= '0;
    end else if (cmd.commit) begin
      case (item.packet_type)
        crte_pkg::PKT_REQUEST: begin
          if (!p_hit && p_free_f) begin
            p_valid[p_free_idx] <= 1'b1;
            p_content[p_free_idx] <= item.content_id;
            p_host[p_free_idx] <= item.host_or_hops;
            p_iface[p_free_idx] <= item.in_interface;
          end
        end
        crte_pkg::PKT_RESPONSE: begin
          if (p_hit) p_valid[p_hit_idx] <= 1'b0;
        end
        crte_pkg::PKT_ANNOUNCE: begin
          if (r_hit) begin
            if (item.host_or_hops < r_hops[r_hit_idx]) r_hops[r_hit_idx] <= item.host_or_hops;
          end else if (r_free_f) begin
            r_valid[r_free_idx] <= 1'b1;
            r_content[r_free_idx] <= item.content_id;
            r_hops[r_free_idx] <= item.host_or_hops;
            r_iface[r_free_idx] <= item.in_interface;
          end
        end
        default: ;
      endcase
    end
  end

  // Form the result beat; pending hit interface is read before commit
  logic [2:0] p_hit_iface;
  always_ff @(posedge clk) begin
    if (cmd.scan && stat.scan_done) p_hit_iface <= p_iface[p_hit_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_bcast) begin
      res.send <= 1'b1;
      res.out_interface <= if_idx[2:0];
      res.hops_out <= item.host_or_hops + 8'd1;
      res.status <= status;
      res.last <= stat.if_last;
    end else if (cmd.emit_single) begin
      res.status <= status;
      res.last <= 1'b1;
      if (item.packet_type == crte_pkg::PKT_REQUEST && r_hit) begin
        res.send <= 1'b1;
        res.out_interface <= r_iface[r_hit_idx];
        res.hops_out <= item.host_or_hops;
      end else if (item.packet_type == crte_pkg::PKT_RESPONSE && p_hit) begin
        res.send <= 1'b1;
        res.out_interface <= p_hit_iface;
        res.hops_out <= item.host_or_hops;
      end else begin
        res.send <= 1'b0;
        res.out_interface <= '0;
        res.hops_out <= '0;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/crte_ctrl.sv @@
// Controller state machine: accept, scan, commit, emit result beats.
// Depends on crte_pkg.
`default_nettype none
module crte_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output crte_pkg::dp_cmd_t  cmd,
  input  crte_pkg::dp_stat_t stat
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_COMMIT = 3'd2;
  localparam logic [2:0] S_BCAST = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_LASTWAIT = 3'd5;

  logic [2:0] state, state_next;
  logic out_busy;
  logic saw_send, saw_send_next;

  assign out_busy = out_valid && !out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    saw_send_next = saw_send;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = !stat.scan_done;
        if (stat.scan_done) begin
          cmd.scan = 1'b1;
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (!out_busy) begin
          cmd.commit = 1'b1;
          saw_send_next = 1'b0;
          if (stat.packet_type == crte_pkg::PKT_ANNOUNCE) begin
            state_next = S_BCAST;
          end else begin
            cmd.emit_single = 1'b1;
            state_next = S_LASTWAIT;
          end
        end
      end
      S_BCAST: begin
        if (!out_busy) begin
          if (stat.if_done) begin
            if (!saw_send) begin
              cmd.emit_single = 1'b1;
            end
            state_next = S_LASTWAIT;
          end else begin
            cmd.if_step = 1'b1;
            if (!stat.if_skip) begin
              cmd.emit_bcast = 1'b1;
              saw_send_next = 1'b1;
              if (stat.if_last) state_next = S_LASTWAIT;
            end
          end
        end
      end
      S_LASTWAIT: begin
        if (!out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output valid: set on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      saw_send <= 1'b0;
    end else begin
      state <= state_next;
      saw_send <= saw_send_next;
      if (cmd.emit_bcast || cmd.emit_single) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/crte_checker.sv @@
// Port-level checker for the content router table engine, bound to the top.
// Depends on crte_pkg.
`default_nettype none
module crte_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input crte_pkg::out_item_t out_item
);
  // Never take a header while a result beat is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("header accepted with beat pending");

  // No result beat right after a header is accepted
  a_scan_gap: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("beat during scan");

  // Stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("stalled beat changed");

  // Non-send beats are marked last and carry zero hops_out
  a_nosend: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.send) |-> (out_item.last && out_item.hops_out == 8'd0))
    else $error("non-send beat malformed");
endmodule

bind content_router_table_engine_top crte_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
);
`default_nettype wire
